/* rtl/dxt1_block_decoder_assert.svh */
// Assertion macros for the DXT1 block decoder.
// Clocked on clk and disabled while rst_n is low; the including module provides both.
`ifndef DXT1_BLOCK_DECODER_ASSERT_SVH
`define DXT1_BLOCK_DECODER_ASSERT_SVH

// Same-cycle implication
`define DXT1_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dxt1 block decoder: assertion failed");

// Next-cycle implication
`define DXT1_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dxt1 block decoder: assertion failed");

`endif

/* rtl/dxt1_pkg.sv */
// Shared types, constants and color helpers for the DXT1 block decoder.
// No dependencies; the palette, row emitter and top-level modules import it.
`default_nettype none

package dxt1_pkg;

    localparam int unsigned TEXEL_W    = 32;
    localparam int unsigned COLS       = 4;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = TEXEL_W * COLS;

    localparam logic [1:0]  ROW_FIRST  = 2'd0;
    localparam logic [1:0]  ROW_LAST   = 2'd3;

    localparam logic [31:0] OPAQUE_ALPHA      = 32'hff00_0000;
    localparam logic [31:0] TRANSPARENT_BLACK = 32'h0000_0000;

    // Reciprocal of three in 11 fractional bits, exact for sums up to 765
    localparam logic [19:0] DIV3_MUL = 20'd683;

    typedef logic [TEXEL_W-1:0] texel_t;
    typedef logic [3:0][TEXEL_W-1:0] palette_t;
    typedef logic [COLS-1:0][TEXEL_W-1:0] row_texels_t;

    // One compressed block as held in the input register
    typedef struct packed {
        logic [31:0] index_bits;
        logic [15:0] color_second;
        logic [15:0] color_first;
    } block_t;

    // Load request from the front end into the row emitter
    typedef struct packed {
        logic        valid;
        logic [31:0] index_bits;
        palette_t    palette;
    } row_req_t;

    // Widen RGB565 to opaque ABGR8888 by left shift only
    function automatic texel_t expand_565(input logic [15:0] c);
        return {8'hff, c[4:0], 3'b000, c[10:5], 2'b00, c[15:11], 3'b000};
    endfunction

    // Truncating divide by three of a value up to 765
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [19:0] prod;
        prod = {10'd0, v} * DIV3_MUL;
        return prod[18:11];
    endfunction

endpackage

`default_nettype wire

/* rtl/dxt1_palette.sv */
// Builds the four-entry palette of one block from its two RGB565 endpoints.
// Pure combinational logic; depends on dxt1_pkg.
`default_nettype none

module dxt1_palette (
    input  wire logic [15:0]        color_first,
    input  wire logic [15:0]        color_second,
    output dxt1_pkg::palette_t      palette
);
    import dxt1_pkg::*;

    texel_t     ext_a;
    texel_t     ext_b;
    logic       four_color;
    texel_t     third_a;
    texel_t     third_b;
    texel_t     half_ab;

    assign ext_a      = expand_565(color_first);
    assign ext_b      = expand_565(color_second);
    assign four_color = color_first > color_second;

    // Blend red, green and blue independently; alpha stays opaque
    always_comb
    begin
        logic [7:0] ca;
        logic [7:0] cb;
        logic [8:0] sum_ab;
        third_a = OPAQUE_ALPHA;
        third_b = OPAQUE_ALPHA;
        half_ab = OPAQUE_ALPHA;
        for (int ch = 0; ch < 3; ch++)
        begin
            ca = ext_a[8*ch +: 8];
            cb = ext_b[8*ch +: 8];
            sum_ab = {1'b0, ca} + {1'b0, cb};
            third_a[8*ch +: 8] = div3({1'b0, ca, 1'b0} + {2'b00, cb});
            third_b[8*ch +: 8] = div3({2'b00, ca} + {1'b0, cb, 1'b0});
            half_ab[8*ch +: 8] = sum_ab[8:1];
        end
    end

    // Select four-color or three-color palette
    always_comb
    begin
        palette[0] = ext_a;
        palette[1] = ext_b;
        if (four_color)
        begin
            palette[2] = third_a;
            palette[3] = third_b;
        end
        else
        begin
            palette[2] = half_ab;
            palette[3] = TRANSPARENT_BLACK;
        end
    end

endmodule

`default_nettype wire

/* rtl/dxt1_row_emit.sv */
// Holds one decoded block and emits its four texel rows through the output register.
// Depends on dxt1_pkg.
`default_nettype none

module dxt1_row_emit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dxt1_pkg::row_req_t          req,
    output logic                             can_load,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [dxt1_pkg::OUT_DATA_W-1:0]  m_tdata,   // texel_left, texel_mid_left,
                                                        // texel_mid_right, texel_right
    output logic [1:0]                       m_tuser,   // row_number
    output logic                             m_tlast    // last_row
);
    import dxt1_pkg::*;

    logic           blk_valid_reg;
    logic           blk_valid_next;
    palette_t       pal_reg;
    logic [31:0]    sel_reg;
    logic [1:0]     row_reg;
    logic [1:0]     row_next;

    logic           out_valid_reg;
    logic           out_valid_next;
    row_texels_t    texels_reg;
    logic [1:0]     out_row_reg;
    logic           out_last_reg;

    logic           out_free;
    logic           issue;
    logic [7:0]     row_sel;
    row_texels_t    row_texels;

    // Output register is free when empty or its request is being taken
    assign out_free = !out_valid_reg || m_tready;
    assign issue    = blk_valid_reg && out_free;
    assign can_load = !blk_valid_reg || (issue && (row_reg == ROW_LAST));

    // Row 0 takes the top byte of the selectors
    assign row_sel = 8'(sel_reg >> {~row_reg, 3'b000});

    // Look up each column; the top bit pair picks the leftmost texel
    always_comb
    begin
        for (int col = 0; col < COLS; col++)
        begin
            row_texels[col] = pal_reg[row_sel[7-2*col -: 2]];
        end
    end

    // Advance the row counter and block occupancy
    always_comb
    begin
        blk_valid_next = blk_valid_reg;
        row_next       = row_reg;
        if (issue)
        begin
            row_next = row_reg + 2'd1;
            if (row_reg == ROW_LAST)
            begin
                blk_valid_next = 1'b0;
            end
        end
        if (req.valid)
        begin
            blk_valid_next = 1'b1;
            row_next       = ROW_FIRST;
        end
    end

    assign out_valid_next = issue ? 1'b1 : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            row_reg       <= ROW_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold block payload and result payload
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            pal_reg <= req.palette;
            sel_reg <= req.index_bits;
        end
        if (issue)
        begin
            texels_reg   <= row_texels;
            out_row_reg  <= row_reg;
            out_last_reg <= (row_reg == ROW_LAST);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = texels_reg;
    assign m_tuser  = out_row_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/dxt1_block_decoder.sv */
// DXT1 block decoder top level: input register, palette build and row emitter.
// Depends on dxt1_pkg, dxt1_palette, dxt1_row_emit and dxt1_block_decoder_assert.svh.
//
// Usage:
//   s_* takes one compressed block per request: s_tdata = {index_bits,
//   color_second, color_first}, color_first in bits 15:0.
//   m_* gives four requests per block, rows 0 to 3 in order. m_tdata holds the
//   four texels of the row, leftmost in bits 31:0; m_tuser is the row number
//   and m_tlast marks row 3. Texels are packed alpha, blue, green, red (high
//   to low).
//   A block accepted into the input register passes to the emitter's block
//   register and then to the output register when the output is free; rows
//   1..3 follow one per cycle while m_tready is high. The single result port
//   carries one row per cycle and so sets the block rate. The next block waits
//   in the input register and its palette loads in the cycle row 3 leaves the
//   emitter, so rows stream without gaps.
//   When m_tready is low the output request holds and, once the input register
//   is full, s_tready drops. Reset clears all valid flags; no block is in flight.
`default_nettype none
`include "dxt1_block_decoder_assert.svh"

module dxt1_block_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [dxt1_pkg::IN_DATA_W-1:0] s_tdata,  // color_first, color_second,
                                                          // index_bits
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [dxt1_pkg::OUT_DATA_W-1:0]  m_tdata,     // texel_left, texel_mid_left,
                                                          // texel_mid_right, texel_right
    output logic [1:0]                       m_tuser,     // row_number
    output logic                             m_tlast      // last_row
);
    import dxt1_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    block_t     blk_reg;
    logic       s_accept;
    logic       can_load;
    logic       load;
    palette_t   palette;
    row_req_t   req;

    // Hand the held block to the emitter when it can take one
    assign load     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || load;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next = s_accept ? 1'b1 : (in_valid_reg && !load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the incoming block
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            blk_reg <= block_t'(s_tdata);
        end
    end

    dxt1_palette u_palette (
        .color_first  (blk_reg.color_first),
        .color_second (blk_reg.color_second),
        .palette      (palette)
    );

    assign req.valid      = load;
    assign req.index_bits = blk_reg.index_bits;
    assign req.palette    = palette;

    dxt1_row_emit u_row_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Rows of one block follow back to back and in order
    `DXT1_ASSERT_NXT(a_row_follows, m_tvalid && m_tready && !m_tlast,
        m_tvalid && (m_tuser == ($past(m_tuser) + 2'd1)))
    // Last flag marks exactly row 3
    `DXT1_ASSERT_IMP(a_last_row, m_tvalid, m_tlast == (m_tuser == ROW_LAST))
    // A fresh output run always starts at row 0
    `DXT1_ASSERT_IMP(a_start_row0, $rose(m_tvalid), m_tuser == ROW_FIRST)

endmodule

`default_nettype wire
